// File: rtl/clai_pkg.sv
package clai_pkg;

  localparam int MAX_STEPS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int MULW  = 33;   // multiplier operand width
  localparam int PRODW = 66;
  localparam int WIDEW = 72;   // headroom for rounding and sums
  localparam int MAGW  = 50;   // |L - target| fits well below this

  // Gauss-Legendre nodes and weights, Q30 rounded to nearest
  localparam longint W_OUTER = ((64'd236926885 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint W_INNER = ((64'd478628670 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint W_MID   = ((64'd568888889 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint N_OUTER = ((64'd906179846 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint N_INNER = ((64'd538469310 << 30) + 64'd500000000) / 64'd1000000000;

  localparam logic [1:0] REG_CUBIC  = 2'd0;
  localparam logic [1:0] REG_SQUARE = 2'd1;
  localparam logic [1:0] REG_LINEAR = 2'd2;
  localparam logic [1:0] REG_TOL    = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [WIDEW-1:0] v);
    logic signed [31:0] res;
    if (v > $signed({{(WIDEW-31){1'b0}}, {31{1'b1}}}))
      res = 32'sh7FFF_FFFF;
    else if (v < -$signed({{(WIDEW-32){1'b0}}, 1'b1, {31{1'b0}}}))
      res = 32'sh8000_0000;
    else
      res = v[31:0];
    return res;
  endfunction

  // round half up, then arithmetic shift
  function automatic logic signed [WIDEW-1:0] rnd_shr(input logic signed [WIDEW-1:0] v,
                                                       input int k);
    logic signed [WIDEW-1:0] one;
    one = {{(WIDEW-1){1'b0}}, 1'b1};
    return (v + (one <<< (k - 1))) >>> k;
  endfunction

endpackage

// File: rtl/clai_mul.sv
module clai_mul (
  input  logic                               clk,
  input  logic signed [clai_pkg::MULW-1:0]   op_a,
  input  logic signed [clai_pkg::MULW-1:0]   op_b,
  output logic signed [clai_pkg::PRODW-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// File: rtl/clai_sqrt.sv
module clai_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done_r,
  output logic [31:0] root
);

  logic [63:0] v_r, res_r, bit_r;
  logic        busy_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign root  = res_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one digit per cycle, from bit 62 down
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

// File: rtl/clai_div.sv
module clai_div #(
  parameter int DW = 66
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done_r,
  output logic [33:0]   quot
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_r;
  logic [31:0]   rem_r;
  logic [33:0]   q_r;
  logic          ovf_r;
  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [32:0]   trial;
  logic          ge;

  assign trial = {rem_r, dvd_r[DW-1]};
  assign ge    = trial >= {1'b0, divisor};
  // anything at or above 2^33 saturates the x update the same way
  assign quot  = (ovf_r || q_r[33]) ? {1'b1, 33'd0} : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(DW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 32'(trial - {1'b0, divisor}) : trial[31:0];
      dvd_r <= dvd_r << 1;
      ovf_r <= ovf_r | q_r[33];
      q_r   <= {q_r[32:0], ge};
      cnt_r <= cnt_r + CW'(1);
    end
  end

endmodule

// File: rtl/cubic_arc_length_inverse.sv
// Channel   Ports                                           Handshake
// input     in_start_x, in_guess_x, in_target_length        start & !busy
// result    out_end_x, out_converged, out_steps_taken       out_valid, one cycle
// config    cfg_we, cfg_index, cfg_data                     cfg_we, immediate
//
// One shared multiplier, a digit-serial square root and a bit-serial
// divider under one sequencer. The arc length runs the setup states
// A0-A3, five integrand evaluations and the quadrature states Q0-Q7;
// each Newton step evaluates the integrand at x for the slope, runs the
// divider, then recomputes the arc length.
// busy is high from accept until out_valid; the receiver cannot stall.
// Reset is synchronous; no clearing pass.
module cubic_arc_length_inverse #(
  parameter int MAX_STEPS = clai_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = clai_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_guess_x,
  input  logic signed [31:0] in_target_length,
  output logic               out_valid,
  output logic signed [31:0] out_end_x,
  output logic               out_converged,
  output logic [5:0]         out_steps_taken,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int WIDEW = clai_pkg::WIDEW;
  localparam int MULW  = clai_pkg::MULW;
  localparam int PRODW = clai_pkg::PRODW;
  localparam int MAGW  = clai_pkg::MAGW;
  localparam int DW    = MAGW + FRAC_BITS;
  localparam int SW    = $clog2(MAX_STEPS + 1);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_A0   = 5'd1;
  localparam logic [4:0] ST_A1   = 5'd2;
  localparam logic [4:0] ST_A2   = 5'd3;
  localparam logic [4:0] ST_A3   = 5'd4;
  localparam logic [4:0] ST_P    = 5'd5;
  localparam logic [4:0] ST_E0   = 5'd6;
  localparam logic [4:0] ST_E1   = 5'd7;
  localparam logic [4:0] ST_E2   = 5'd8;
  localparam logic [4:0] ST_E3   = 5'd9;
  localparam logic [4:0] ST_E4   = 5'd10;
  localparam logic [4:0] ST_E5   = 5'd11;
  localparam logic [4:0] ST_E6   = 5'd12;
  localparam logic [4:0] ST_E7   = 5'd13;
  localparam logic [4:0] ST_Q0   = 5'd14;
  localparam logic [4:0] ST_Q1   = 5'd15;
  localparam logic [4:0] ST_Q2   = 5'd16;
  localparam logic [4:0] ST_Q3   = 5'd17;
  localparam logic [4:0] ST_Q4   = 5'd18;
  localparam logic [4:0] ST_Q5   = 5'd19;
  localparam logic [4:0] ST_Q6   = 5'd20;
  localparam logic [4:0] ST_Q7   = 5'd21;
  localparam logic [4:0] ST_D0   = 5'd22;
  localparam logic [4:0] ST_D1   = 5'd23;

  logic [4:0] state_r;

  logic signed [31:0] coef_a_r, coef_b_r, coef_c_r;
  logic [30:0]        tol_r;

  logic signed [31:0] x1_r, x_r, tgt_r;
  logic signed [31:0] r_r, s_r, o1_r, o2_r, p_r;
  logic signed [31:0] t_r, u_r, v_r, m_r;
  logic [31:0]        dmag_r;
  logic [31:0]        g_r [5];
  logic [31:0]        gx_r;
  logic signed [PRODW-1:0] acc_r;
  logic [MAGW-1:0]    mag_r;
  logic               neg_r;
  logic [SW-1:0]      steps_r;
  logic [2:0]         k_r;
  logic               ret_r;

  logic signed [MULW-1:0]  mul_a, mul_b;
  logic signed [PRODW-1:0] prod_r;
  logic signed [WIDEW-1:0] pext;

  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic [31:0] g_sat;
  logic        dv_start, dv_done;
  logic [33:0] dv_quot;

  logic signed [WIDEW-1:0] point_w, dsum, lval, diff;
  logic signed [35:0]      xn;
  logic [SW+5:0]           steps_ext;

  assign pext      = {{(WIDEW-PRODW){prod_r[PRODW-1]}}, prod_r};
  assign busy      = state_r != ST_IDLE;
  assign g_sat     = sq_root[31] ? 32'h7FFF_FFFF : sq_root;
  assign steps_ext = {6'd0, steps_r};

  clai_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  clai_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (prod_r[63:0] + (64'd1 << (2 * FRAC_BITS))),
    .done_r   (sq_done),
    .root     (sq_root)
  );

  clai_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend ({mag_r, {FRAC_BITS{1'b0}}}),
    .divisor  (gx_r),
    .done_r   (dv_done),
    .quot     (dv_quot)
  );

  assign sq_start = state_r == ST_E6;
  assign dv_start = state_r == ST_D0;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_A1: begin
        mul_a = MULW'(s_r);
        mul_b = MULW'(clai_pkg::N_OUTER);
      end
      ST_A2: begin
        mul_a = MULW'(s_r);
        mul_b = MULW'(clai_pkg::N_INNER);
      end
      ST_E0: begin
        mul_a = MULW'(p_r);
        mul_b = MULW'(p_r);
      end
      ST_E1: begin
        mul_a = MULW'(coef_b_r);
        mul_b = MULW'(p_r);
      end
      ST_E2: begin
        mul_a = MULW'(coef_a_r);
        mul_b = MULW'(t_r);
      end
      ST_E5: begin
        mul_a = {1'b0, dmag_r};
        mul_b = {1'b0, dmag_r};
      end
      ST_Q0: begin
        mul_a = MULW'(clai_pkg::W_OUTER);
        mul_b = MULW'({1'b0, g_r[0]}) + MULW'({1'b0, g_r[1]});
      end
      ST_Q1: begin
        mul_a = MULW'(clai_pkg::W_INNER);
        mul_b = MULW'({1'b0, g_r[2]}) + MULW'({1'b0, g_r[3]});
      end
      ST_Q2: begin
        mul_a = MULW'(clai_pkg::W_MID);
        mul_b = MULW'({1'b0, g_r[4]});
      end
      ST_Q5: begin
        mul_a = MULW'(s_r);
        mul_b = MULW'(m_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (k_r)
      3'd0:    point_w = WIDEW'(r_r) - WIDEW'(o1_r);
      3'd1:    point_w = WIDEW'(r_r) + WIDEW'(o1_r);
      3'd2:    point_w = WIDEW'(r_r) - WIDEW'(o2_r);
      3'd3:    point_w = WIDEW'(r_r) + WIDEW'(o2_r);
      default: point_w = WIDEW'(r_r);
    endcase
  end

  assign dsum = 3 * WIDEW'(u_r) + 2 * WIDEW'(v_r) + WIDEW'(coef_c_r);
  assign lval = clai_pkg::rnd_shr(pext, FRAC_BITS);
  assign diff = lval - WIDEW'(tgt_r);
  assign xn   = neg_r ? (36'(x_r) + $signed({2'b00, dv_quot}))
                      : (36'(x_r) - $signed({2'b00, dv_quot}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= '0;
      coef_b_r <= '0;
      coef_c_r <= '0;
      tol_r    <= 31'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        clai_pkg::REG_CUBIC:  coef_a_r <= cfg_data;
        clai_pkg::REG_SQUARE: coef_b_r <= cfg_data;
        clai_pkg::REG_LINEAR: coef_c_r <= cfg_data;
        clai_pkg::REG_TOL:    tol_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            x1_r    <= in_start_x;
            x_r     <= in_guess_x;
            tgt_r   <= in_target_length;
            steps_r <= '0;
            state_r <= ST_A0;
          end
        end
        ST_A0: begin
          r_r     <= 32'((WIDEW'(x1_r) + WIDEW'(x_r)) >>> 1);
          s_r     <= 32'((WIDEW'(x_r) - WIDEW'(x1_r)) >>> 1);
          state_r <= ST_A1;
        end
        ST_A1: state_r <= ST_A2;
        ST_A2: begin
          o1_r    <= 32'(clai_pkg::rnd_shr(pext, 30));
          state_r <= ST_A3;
        end
        ST_A3: begin
          o2_r    <= 32'(clai_pkg::rnd_shr(pext, 30));
          k_r     <= '0;
          state_r <= ST_P;
        end
        ST_P: begin
          p_r     <= clai_pkg::sat32(point_w);
          ret_r   <= 1'b0;
          state_r <= ST_E0;
        end
        ST_E0: state_r <= ST_E1;
        ST_E1: begin
          t_r     <= clai_pkg::sat32(clai_pkg::rnd_shr(pext, FRAC_BITS));
          state_r <= ST_E2;
        end
        ST_E2: begin
          v_r     <= clai_pkg::sat32(clai_pkg::rnd_shr(pext, FRAC_BITS));
          state_r <= ST_E3;
        end
        ST_E3: begin
          u_r     <= clai_pkg::sat32(clai_pkg::rnd_shr(pext, FRAC_BITS));
          state_r <= ST_E4;
        end
        ST_E4: begin
          dmag_r  <= dsum[WIDEW-1] ? 32'(-clai_pkg::sat32(dsum))
                                   : 32'(clai_pkg::sat32(dsum));
          state_r <= ST_E5;
        end
        ST_E5: state_r <= ST_E6;
        ST_E6: state_r <= ST_E7;
        ST_E7: begin
          if (sq_done) begin
            if (ret_r) begin
              gx_r    <= g_sat;
              state_r <= ST_D0;
            end else begin
              g_r[k_r] <= g_sat;
              k_r      <= k_r + 3'd1;
              state_r  <= (k_r == 3'd4) ? ST_Q0 : ST_P;
            end
          end
        end
        ST_Q0: state_r <= ST_Q1;
        ST_Q1: begin
          acc_r   <= prod_r;
          state_r <= ST_Q2;
        end
        ST_Q2: begin
          acc_r   <= acc_r + prod_r;
          state_r <= ST_Q3;
        end
        ST_Q3: begin
          acc_r   <= acc_r + prod_r;
          state_r <= ST_Q4;
        end
        ST_Q4: begin
          m_r     <= clai_pkg::sat32(clai_pkg::rnd_shr(
                       {{(WIDEW-PRODW){acc_r[PRODW-1]}}, acc_r}, 30));
          state_r <= ST_Q5;
        end
        ST_Q5: state_r <= ST_Q6;
        ST_Q6: begin
          neg_r   <= diff[WIDEW-1];
          mag_r   <= diff[WIDEW-1] ? MAGW'(-diff) : MAGW'(diff);
          state_r <= ST_Q7;
        end
        ST_Q7: begin
          if (mag_r > MAGW'(tol_r) && steps_r < SW'(MAX_STEPS)) begin
            p_r     <= x_r;
            ret_r   <= 1'b1;
            state_r <= ST_E0;
          end else begin
            out_valid       <= 1'b1;
            out_end_x       <= x_r;
            out_converged   <= mag_r <= MAGW'(tol_r);
            out_steps_taken <= steps_ext[5:0];
            state_r         <= ST_IDLE;
          end
        end
        ST_D0: state_r <= ST_D1;
        ST_D1: begin
          if (dv_done) begin
            x_r     <= clai_pkg::sat32(WIDEW'(xn));
            steps_r <= steps_r + SW'(1);
            state_r <= ST_A0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
